// File: src/looping_segment_timeline_timer_top_defines.svh
// Assertion macros used by the segment timeline timer datapath.
// Compiled out when SYNTH is defined; no other dependencies.
`ifndef LOOPING_SEGMENT_TIMELINE_TIMER_TOP_DEFINES_SVH
`define LOOPING_SEGMENT_TIMELINE_TIMER_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define LSTT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define LSTT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define LSTT_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LSTT_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/lstt_pkg.sv
// Types and constants for the looping segment timeline timer.
// Used by the controller, the datapath and the top level.
package lstt_pkg;

   localparam int IDX_WIDTH      = 3;
   localparam int DUR_WIDTH      = 24;
   localparam int NUM_DUR        = 7;
   localparam int TOTAL_WIDTH    = 27;
   localparam int ELAPSED_WIDTH  = 10;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 32;
   localparam int RSP_USER_WIDTH = 2;

   localparam logic [IDX_WIDTH-1:0] REG_SEG_COUNT   = 3'd0;
   localparam logic [IDX_WIDTH-1:0] SEG_COUNT_RESET = 3'd1;
   localparam logic [IDX_WIDTH-1:0] NO_DUR_INDEX    = 3'd7;
   localparam logic [DUR_WIDTH-1:0] DUR_RESET       = 24'd1000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_RANGE,
      ST_CHECK,
      ST_LOOP,
      ST_MOD,
      ST_FINISH
   } lstt_state_type;

   typedef struct packed {
      logic load;
      logic sum_step;
      logic range_adv;
      logic stall_set;
      logic mod_start;
      logic mod_step;
      logic seg_step;
      logic commit;
   } lstt_cmd_type;

   typedef struct packed {
      logic sum_done;
      logic out_of_range;
      logic t_ge_d;
      logic total_zero;
      logic mod_hit;
      logic mod_last;
      logic out_free;
   } lstt_status_type;

endpackage

// File: src/lstt_controller.sv
// Sequencer for the segment timeline timer: walks one tick through
// sum, range check, segment steps and wrap removal. Depends on lstt_pkg.
module lstt_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  lstt_pkg::lstt_status_type status,
   output lstt_pkg::lstt_cmd_type    cmd
);
   import lstt_pkg::*;

   lstt_state_type state_ff;
   lstt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (status.sum_done) begin
               state_in = ST_RANGE;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         ST_RANGE: begin
            // an index left beyond the count must finish its own segment first
            if (status.out_of_range) begin
               if (status.t_ge_d) begin
                  cmd.range_adv = 1'b1;
                  state_in      = ST_CHECK;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.total_zero) begin
               cmd.stall_set = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            priority if (status.mod_hit) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else if (!status.t_ge_d) begin
               state_in = ST_FINISH;
            end else begin
               cmd.seg_step = 1'b1;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_LOOP;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
      endcase
   end

endmodule

// File: src/lstt_datapath.sv
// Datapath of the segment timeline timer: configuration registers, timeline
// state, working registers, remainder unit and result register.
// Depends on lstt_pkg and the project assertion macros.
`include "looping_segment_timeline_timer_top_defines.svh"
module lstt_datapath #(
   parameter int TIME_WIDTH   = 24,
   parameter int MAX_SEGMENTS = 7
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [lstt_pkg::IDX_WIDTH-1:0]        csr_index,
   input  logic [lstt_pkg::DUR_WIDTH-1:0]        csr_data,
   input  logic [lstt_pkg::ELAPSED_WIDTH-1:0]    elapsed_ms,
   input  lstt_pkg::lstt_cmd_type                cmd,
   output lstt_pkg::lstt_status_type             status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lstt_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   output logic [lstt_pkg::RSP_USER_WIDTH-1:0]   rsp_tuser
);
   import lstt_pkg::*;

   localparam int CW  = (TIME_WIDTH + 1 > TOTAL_WIDTH) ? TIME_WIDTH + 1 : TOTAL_WIDTH;
   localparam int MCW = $clog2(CW);
   localparam logic [CW-1:0] TMAX = {{(CW - TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
   localparam logic [IDX_WIDTH-1:0] MAX_SEG = IDX_WIDTH'(MAX_SEGMENTS);
   localparam logic [MCW-1:0] MOD_LAST_CNT = MCW'(CW - 1);

   // configuration
   logic [IDX_WIDTH-1:0] seg_count_ff;
   logic [DUR_WIDTH-1:0] dur_ff [NUM_DUR];

   // timeline state
   logic [IDX_WIDTH-1:0]  cur_seg_ff, cur_seg_in;
   logic [TIME_WIDTH-1:0] seg_time_ff, seg_time_in;

   // working registers
   logic [CW-1:0]        t_ff, t_in;
   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [IDX_WIDTH-1:0] sum_i_ff, sum_i_in;
   logic                 sum_busy_ff, sum_busy_in;
   logic                 changed_ff, changed_in;
   logic                 stall_ff, stall_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [MCW-1:0]       mod_cnt_ff, mod_cnt_in;

   // result register
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [IDX_WIDTH-1:0] rsp_idx_ff, rsp_idx_in;
   logic [DUR_WIDTH-1:0] rsp_time_ff, rsp_time_in;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic                 rsp_stall_ff, rsp_stall_in;

   logic [IDX_WIDTH-1:0] n_used;
   logic [IDX_WIDTH-1:0] rd_addr;
   logic [DUR_WIDTH-1:0] rd_dur;
   logic [CW-1:0]        d_cw;
   logic [CW-1:0]        t_sub_d;
   logic [IDX_WIDTH:0]   idx_inc;
   logic [IDX_WIDTH-1:0] idx_next;
   logic [CW:0]          rem_sh;
   logic [CW-1:0]        rem_next;
   logic [CW-1:0]        t_load;
   logic [CW-1:0]        t_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_COUNT_RESET;
         for (int i = 0; i < NUM_DUR; i++) begin
            dur_ff[i] <= DUR_RESET;
         end
      end else if (csr_valid) begin
         if (csr_index == REG_SEG_COUNT) begin
            seg_count_ff <= csr_data[IDX_WIDTH-1:0];
         end else begin
            dur_ff[csr_index - IDX_WIDTH'(1)] <= csr_data;
         end
      end
   end

   always_comb begin
      n_used = seg_count_ff;
      if (seg_count_ff == '0) begin
         n_used = IDX_WIDTH'(1);
      end else if (seg_count_ff > MAX_SEG) begin
         n_used = MAX_SEG;
      end
   end

   // single read port on the duration bank; an index with no register reads zero
   assign rd_addr  = sum_busy_ff ? sum_i_ff : idx_ff;
   assign rd_dur   = (rd_addr == NO_DUR_INDEX) ? '0 : dur_ff[rd_addr];
   assign d_cw     = CW'(rd_dur);
   assign t_sub_d  = t_ff - d_cw;
   assign idx_inc  = {1'b0, idx_ff} + (IDX_WIDTH + 1)'(1);
   assign idx_next = (idx_inc >= {1'b0, n_used}) ? '0 : idx_inc[IDX_WIDTH-1:0];
   assign t_load   = CW'(seg_time_ff) + CW'(elapsed_ms);
   assign t_sat    = (t_ff > TMAX) ? TMAX : t_ff;

   // restoring remainder, one bit of t per cycle, MSB first
   assign rem_sh   = {rem_ff, t_ff[CW-1]};
   assign rem_next = (rem_sh >= {1'b0, total_ff}) ? CW'(rem_sh - {1'b0, total_ff})
                                                  : rem_sh[CW-1:0];

   always_comb begin
      status.sum_done     = !sum_busy_ff;
      status.out_of_range = idx_ff >= n_used;
      status.t_ge_d       = t_ff >= d_cw;
      status.total_zero   = total_ff == '0;
      status.mod_hit      = (idx_ff == '0) && (t_ff >= total_ff);
      status.mod_last     = mod_cnt_ff == MOD_LAST_CNT;
      status.out_free     = !rsp_tvalid_ff || rsp_tready;
   end

   always_comb begin
      t_in           = t_ff;
      idx_in         = idx_ff;
      total_in       = total_ff;
      sum_i_in       = sum_i_ff;
      sum_busy_in    = sum_busy_ff;
      changed_in     = changed_ff;
      stall_in       = stall_ff;
      rem_in         = rem_ff;
      mod_cnt_in     = mod_cnt_ff;
      cur_seg_in     = cur_seg_ff;
      seg_time_in    = seg_time_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_stall_in   = rsp_stall_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;

      if (cmd.load) begin
         t_in        = t_load;
         idx_in      = cur_seg_ff;
         total_in    = '0;
         sum_i_in    = '0;
         sum_busy_in = 1'b1;
         changed_in  = 1'b0;
         stall_in    = 1'b0;
      end
      if (cmd.sum_step) begin
         total_in = total_ff + d_cw;
         sum_i_in = sum_i_ff + IDX_WIDTH'(1);
         if (sum_i_ff == n_used - IDX_WIDTH'(1)) begin
            sum_busy_in = 1'b0;
         end
      end
      if (cmd.range_adv) begin
         t_in       = t_sub_d;
         idx_in     = '0;
         changed_in = 1'b1;
      end
      if (cmd.stall_set) begin
         t_in     = '0;
         stall_in = 1'b1;
      end
      if (cmd.mod_start) begin
         rem_in     = '0;
         mod_cnt_in = '0;
         changed_in = 1'b1;
      end
      if (cmd.mod_step) begin
         rem_in     = rem_next;
         mod_cnt_in = mod_cnt_ff + MCW'(1);
         t_in       = status.mod_last ? rem_next : {t_ff[CW-2:0], 1'b0};
      end
      if (cmd.seg_step) begin
         t_in       = t_sub_d;
         idx_in     = idx_next;
         changed_in = 1'b1;
      end
      if (cmd.commit) begin
         cur_seg_in     = idx_ff;
         seg_time_in    = t_sat[TIME_WIDTH-1:0];
         rsp_idx_in     = idx_ff;
         rsp_time_in    = t_sat[DUR_WIDTH-1:0];
         rsp_changed_in = changed_ff;
         rsp_stall_in   = stall_ff;
         rsp_tvalid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_seg_ff    <= '0;
         seg_time_ff   <= '0;
         sum_busy_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cur_seg_ff    <= cur_seg_in;
         seg_time_ff   <= seg_time_in;
         sum_busy_ff   <= sum_busy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff           <= t_in;
      idx_ff         <= idx_in;
      total_ff       <= total_in;
      sum_i_ff       <= sum_i_in;
      changed_ff     <= changed_in;
      stall_ff       <= stall_in;
      rem_ff         <= rem_in;
      mod_cnt_ff     <= mod_cnt_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_stall_ff   <= rsp_stall_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_time_ff, rsp_idx_ff});
   assign rsp_tuser  = {rsp_stall_ff, rsp_changed_ff};

   `LSTT_ASSERT_NXT(a_commit_shows_word, clock, reset, cmd.commit, rsp_tvalid_ff)
   `LSTT_ASSERT_NXT(a_commit_index_match, clock, reset, cmd.commit, cur_seg_ff == rsp_idx_ff)
   `LSTT_ASSERT_IMP(a_stall_time_zero, clock, reset, rsp_tvalid_ff && rsp_stall_ff, rsp_time_ff == '0)

endmodule

// File: src/looping_segment_timeline_timer_top.sv
// Top level of the looping segment timeline timer: controller plus datapath.
// Depends on lstt_pkg, lstt_controller and lstt_datapath.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------------
//   req      | in        | req_tvalid/req_tready  | elapsed_ms
//   rsp      | out       | rsp_tvalid/rsp_tready  | segment_index, time_in_segment, flags
//   csr      | in        | csr_valid/csr_ready    | register index, write data
//
// One word at a time: the sum reads the n segments in use, each passed segment
// takes a step, and whole loops are removed by the bit-serial remainder unit
// (CW = max(TIME_WIDTH + 1, 27) bits), which sets the worst case. The next
// word is taken while a result waits in the output register; a stalled rsp
// side holds the block in its finish state. Reset clears the index and time
// and loads segment_count = 1 and every duration = 1000.
module looping_segment_timeline_timer_top #(
   parameter int TIME_WIDTH   = 24,
   parameter int MAX_SEGMENTS = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lstt_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,  // [9:0] elapsed_ms
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [lstt_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // [2:0] segment_index,
                                                            // [26:3] time_in_segment
   output logic [lstt_pkg::RSP_USER_WIDTH-1:0]  rsp_tuser,  // [0] segment_changed,
                                                            // [1] stalled
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lstt_pkg::IDX_WIDTH-1:0]       csr_index,
   input  logic [lstt_pkg::DUR_WIDTH-1:0]       csr_data
);
   import lstt_pkg::*;

   lstt_cmd_type    cmd;
   lstt_status_type status;

   // registers are plain flops, so a write is always taken
   assign csr_ready = 1'b1;

   lstt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lstt_datapath #(
      .TIME_WIDTH   (TIME_WIDTH),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .elapsed_ms (req_tdata[ELAPSED_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
